@@ hdl/jpeg_frame_header_scanner_core_macros.svh @@
// Assertion macros used by the frame header scanner checker.
`ifndef JPEG_FRAME_HEADER_SCANNER_CORE_MACROS_SVH
`define JPEG_FRAME_HEADER_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JFHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("jfhs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JFHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("jfhs check failed");

`endif

@@ hdl/jfhs_pkg.sv @@
// Shared types and constants of the frame header scanner.
package jfhs_pkg;

	localparam int POSITION_BITS = 32;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] MARK_SOF0   = 8'hC0;
	localparam logic [7:0] MARK_SOF2   = 8'hC2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] height;
		logic [15:0] width;
	} res_t;

endpackage

@@ hdl/jfhs_in_reg.sv @@
// Input register stage holding one byte transaction.
module jfhs_in_reg import jfhs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic vld_q;

	assign in_ready = !vld_q || advance;
	assign valid_s1 = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hdl/jfhs_parser.sv @@
// Marker walk state and combinational next-state logic of the scanner.
module jfhs_parser import jfhs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output logic  res_valid,
	output res_t  res
);

	localparam int PW = POSITION_BITS;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SCAN   = 3'd1;
	localparam logic [2:0] PH_MARKER = 3'd2;
	localparam logic [2:0] PH_FRAME  = 3'd3;
	localparam logic [2:0] PH_IDLE   = 3'd4;

	localparam logic [PW-1:0] OFF_CODE   = PW'(1);
	localparam logic [PW-1:0] OFF_LEN_HI = PW'(2);
	localparam logic [PW-1:0] OFF_LEN_LO = PW'(3);
	localparam logic [PW-1:0] OFF_H_HI   = PW'(5);
	localparam logic [PW-1:0] OFF_H_LO   = PW'(6);
	localparam logic [PW-1:0] OFF_W_HI   = PW'(7);
	localparam logic [PW-1:0] OFF_W_LO   = PW'(8);
	localparam logic [PW-1:0] OFF_DONE   = PW'(9);
	localparam logic [PW-1:0] POS_MAX    = {PW{1'b1}};
	localparam logic [PW:0]   TGT_RESET  = (PW+1)'(2);

	logic [2:0]    phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW:0]   tgt_q, tgt_d;
	logic [PW-1:0] mstart_q, mstart_d;
	logic [7:0]    lenh_q, lenh_d;
	logic [15:0]   hcap_q, hcap_d;
	logic [15:0]   wcap_q, wcap_d;
	logic          rep_q, rep_d;

	logic [PW-1:0] off;
	logic [15:0]   seg_len;
	logic [PW:0]   tgt_new;
	logic          hit;
	logic [7:0]    b;

	assign b       = item.data_byte;
	assign off     = pos_q - mstart_q;
	assign seg_len = {lenh_q, b};
	assign tgt_new = (seg_len < 16'd2) ? ({1'b0, mstart_q} + (PW+1)'(4))
	                                   : ({1'b0, mstart_q} + (PW+1)'(seg_len) + (PW+1)'(2));
	assign hit     = (phase_q == PH_FRAME) && (off == OFF_DONE);

	assign res_valid  = hit || (item.last && !rep_q);
	assign res.found  = hit;
	assign res.height = hit ? hcap_q : 16'd0;
	assign res.width  = hit ? wcap_q : 16'd0;

	always_comb begin
		phase_d  = phase_q;
		tgt_d    = tgt_q;
		mstart_d = mstart_q;
		lenh_d   = lenh_q;
		hcap_d   = hcap_q;
		wcap_d   = wcap_q;
		rep_d    = rep_q;
		pos_d    = (pos_q != POS_MAX) ? pos_q + PW'(1) : pos_q;
		case (phase_q)
			PH_START: begin
				if (pos_q == '0) begin
					if (b != MARK_PREFIX) phase_d = PH_IDLE;
				end else begin
					phase_d = (b == MARK_SOI) ? PH_SCAN : PH_IDLE;
				end
			end
			PH_SCAN: begin
				if (({1'b0, pos_q} >= tgt_q) && (b == MARK_PREFIX)) begin
					mstart_d = pos_q;
					phase_d  = PH_MARKER;
				end
			end
			PH_MARKER: begin
				if (off == OFF_CODE) begin
					if (b == MARK_SOF0 || b == MARK_SOF2) phase_d = PH_FRAME;
				end else if (off == OFF_LEN_HI) begin
					lenh_d = b;
				end else if (off == OFF_LEN_LO) begin
					tgt_d   = tgt_new;
					phase_d = PH_SCAN;
				end
			end
			PH_FRAME: begin
				if (off == OFF_H_HI)      hcap_d[15:8] = b;
				else if (off == OFF_H_LO) hcap_d[7:0]  = b;
				else if (off == OFF_W_HI) wcap_d[15:8] = b;
				else if (off == OFF_W_LO) wcap_d[7:0]  = b;
				else if (hit) begin
					rep_d   = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: ;
		endcase
		// End of file: drop everything and start over on the next byte.
		if (item.last) begin
			phase_d  = PH_START;
			pos_d    = '0;
			tgt_d    = TGT_RESET;
			mstart_d = '0;
			lenh_d   = 8'd0;
			hcap_d   = 16'd0;
			wcap_d   = 16'd0;
			rep_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			pos_q    <= '0;
			tgt_q    <= TGT_RESET;
			mstart_q <= '0;
			lenh_q   <= 8'd0;
			hcap_q   <= 16'd0;
			wcap_q   <= 16'd0;
			rep_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			tgt_q    <= tgt_d;
			mstart_q <= mstart_d;
			lenh_q   <= lenh_d;
			hcap_q   <= hcap_d;
			wcap_q   <= wcap_d;
			rep_q    <= rep_d;
		end
	end

endmodule

@@ hdl/jfhs_out_reg.sv @@
// Result register holding one result transaction until it is taken.
module jfhs_out_reg import jfhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	output logic out_valid,
	input  logic out_ready,
	output res_t res_out
);

	logic vld_q;
	res_t res_q;

	assign out_valid = vld_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

@@ hdl/jpeg_frame_header_scanner_core.sv @@
// Each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register stalls only while the
//   result register is full and out_ready is low.
// Reset: arst_n clears the parse state to "expect start marker" at offset 0 and
//   empties both registers; the byte with last set also restores that state.
module jpeg_frame_header_scanner_core import jfhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [15:0] height,
	output logic [15:0] width
);

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	logic  res_valid;
	res_t  res_next;
	res_t  res_cur;

	assign in_item.data_byte = data_byte;
	assign in_item.last      = last;

	// Advance the held byte whenever the result register can take a result
	// this cycle: it is empty, or its transaction completes now.
	assign advance = valid_s1 && (!out_valid || out_ready);

	jfhs_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Walk the markers: one compare-and-update pass per byte.
	jfhs_parser u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res_next)
	);

	// Hold the result until the consumer takes it.
	jfhs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res_next),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_cur)
	);

	assign found  = res_cur.found;
	assign height = res_cur.height;
	assign width  = res_cur.width;

endmodule

@@ hdl/jfhs_checker.sv @@
// Port-level checks of the frame header scanner and their bind.
`include "jpeg_frame_header_scanner_core_macros.svh"

module jfhs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [15:0] height,
	input logic [15:0] width
);

	`JFHS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(height) && $stable(width))
	`JFHS_ASSERT_NOW(a_miss_zero, clk, arst_n, out_valid && !found, height == 16'd0 && width == 16'd0)
	`JFHS_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind jpeg_frame_header_scanner_core jfhs_checker u_jfhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.height    (height),
	.width     (width)
);

@@ tb/sv/jpeg_frame_header_scanner_core_test.sv @@
// Self-checking testbench for the JPEG frame header scanner: byte stream in, frame size out.
`timescale 1ns / 100ps

module jpeg_frame_header_scanner_core_test;
	import jfhs_pkg::*;

	// Markers that appear in the stimulus besides the ones the package names.
	localparam logic [7:0] MARK_APP0 = 8'hE0;
	localparam logic [7:0] MARK_DQT  = 8'hDB;
	localparam logic [7:0] MARK_SOF1 = 8'hC1;
	localparam logic [7:0] MARK_EOI  = 8'hD9;

	localparam int RANDOM_BYTES = 360;

	typedef logic [7:0] byte_list_t[$];

	// One queued transaction for the driver; hold_for_drain makes it wait for
	// every outstanding frame size to be checked before it goes out.
	typedef struct {
		item_t it;
		bit    hold_for_drain;
	} stream_tx_t;

	typedef enum logic [2:0] {
		SC_SOI,
		SC_HUNT,
		SC_MARKER,
		SC_FRAME,
		SC_DONE
	} scan_phase_e;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_QUARTER,
		RDY_BURSTY
	} ready_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [15:0] height;
	logic [15:0] width;

	stream_tx_t  byte_stream[$];
	res_t        pending_sizes[$];
	int          err_count = 0;
	int          random_bytes = 0;

	// Scanner state as the predictor tracks it.
	scan_phase_e              sc_phase;
	logic [POSITION_BITS-1:0] sc_pos;
	logic [POSITION_BITS:0]   sc_target;
	logic [POSITION_BITS-1:0] sc_mark;
	logic [7:0]               sc_len_hi;
	logic [15:0]              sc_height;
	logic [15:0]              sc_width;
	logic                     sc_reported;

	jpeg_frame_header_scanner_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.height    (height),
		.width     (width)
	);

	always #4 clk = ~clk;

	// Return the scanner to its start-of-file state.
	task automatic clear_scan_state();
		sc_phase    = SC_SOI;
		sc_pos      = '0;
		sc_target   = (POSITION_BITS+1)'(2);
		sc_mark     = '0;
		sc_len_hi   = '0;
		sc_height   = '0;
		sc_width    = '0;
		sc_reported = 1'b0;
	endtask

	// Advance the scanner by one accepted byte and queue the frame size it yields.
	task automatic predict_frame_size(input logic [7:0] b, input logic lst);
		logic [POSITION_BITS-1:0] off;
		logic [15:0]              seg_len;
		res_t                     r;
		bit                       given;
		off   = sc_pos - sc_mark;
		given = 1'b0;
		case (sc_phase)
			SC_SOI: begin
				if (sc_pos == 0) begin
					if (b != MARK_PREFIX)
						sc_phase = SC_DONE;
				end else begin
					sc_phase = (b == MARK_SOI) ? SC_HUNT : SC_DONE;
				end
			end
			SC_HUNT: begin
				// Match 0xFF only once the previous segment has been stepped over.
				if ({1'b0, sc_pos} >= sc_target && b == MARK_PREFIX) begin
					sc_mark  = sc_pos;
					sc_phase = SC_MARKER;
				end
			end
			SC_MARKER: begin
				if (off == 1) begin
					if (b == MARK_SOF0 || b == MARK_SOF2)
						sc_phase = SC_FRAME;
				end else if (off == 2) begin
					sc_len_hi = b;
				end else if (off == 3) begin
					// Short lengths resume the scan right after the length field.
					seg_len = {sc_len_hi, b};
					if (seg_len < 2)
						sc_target = {1'b0, sc_mark} + 4;
					else
						sc_target = {1'b0, sc_mark} + 2 + seg_len;
					sc_phase = SC_HUNT;
				end
			end
			SC_FRAME: begin
				if (off == 5) begin
					sc_height[15:8] = b;
				end else if (off == 6) begin
					sc_height[7:0] = b;
				end else if (off == 7) begin
					sc_width[15:8] = b;
				end else if (off == 8) begin
					sc_width[7:0] = b;
				end else if (off == 9) begin
					r.found  = 1'b1;
					r.height = sc_height;
					r.width  = sc_width;
					pending_sizes.push_back(r);
					given       = 1'b1;
					sc_reported = 1'b1;
					sc_phase    = SC_DONE;
				end
			end
			default: ;
		endcase
		if (sc_pos != '1)
			sc_pos = sc_pos + 1;
		if (lst) begin
			if (!sc_reported && !given) begin
				r.found  = 1'b0;
				r.height = '0;
				r.width  = '0;
				pending_sizes.push_back(r);
			end
			clear_scan_state();
		end
	endtask

	// Queue one file; the final byte carries last.
	task automatic add_file(input byte_list_t f, input bit drain);
		stream_tx_t tx;
		for (int i = 0; i < f.size(); i++) begin
			tx.it.data_byte   = f[i];
			tx.it.last        = (i == f.size() - 1);
			tx.hold_for_drain = drain && (i == 0);
			byte_stream.push_back(tx);
		end
	endtask

	// Build a random file: mostly well-formed headers with random segments and
	// frame contents, some truncated, some pure noise.
	task automatic add_random_file();
		byte_list_t  f;
		int          kind;
		int          nseg;
		int          fill;
		int          cut;
		logic [15:0] seg_len;
		logic [7:0]  mk;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// Noise, sometimes behind a valid start marker.
			if ($urandom_range(0, 1)) begin
				f.push_back(MARK_PREFIX);
				f.push_back(MARK_SOI);
			end
			repeat ($urandom_range(1, 24))
				f.push_back(8'($urandom_range(0, 255)));
		end else begin
			f.push_back(MARK_PREFIX);
			f.push_back(MARK_SOI);
			repeat ($urandom_range(0, 2))
				f.push_back(8'($urandom_range(0, 254)));
			nseg = $urandom_range(0, 3);
			for (int s = 0; s < nseg; s++) begin
				case ($urandom_range(0, 5))
					0: mk = MARK_APP0;
					1: mk = MARK_DQT;
					2: mk = MARK_SOF1;
					3: mk = MARK_PREFIX;
					4: mk = MARK_EOI;
					default: mk = 8'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 7))
					0, 1: seg_len = 16'($urandom_range(0, 1));
					7: seg_len = 16'($urandom_range(0, 16'hFFFF));
					default: seg_len = 16'($urandom_range(2, 10));
				endcase
				f.push_back(MARK_PREFIX);
				f.push_back(mk);
				f.push_back(seg_len[15:8]);
				f.push_back(seg_len[7:0]);
				// Cap the payload of huge segments; the file then ends inside it.
				fill = (seg_len >= 2) ? seg_len - 2 : 0;
				if (fill > 12)
					fill = 12;
				repeat (fill)
					f.push_back(8'($urandom_range(0, 255)));
			end
			f.push_back(MARK_PREFIX);
			f.push_back($urandom_range(0, 1) ? MARK_SOF0 : MARK_SOF2);
			repeat (7)
				f.push_back(8'($urandom_range(0, 255)));
			f.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4))
				f.push_back(8'($urandom_range(0, 255)));
			if (kind == 1) begin
				cut = $urandom_range(1, f.size());
				while (f.size() > cut)
					void'(f.pop_back());
			end
		end
		random_bytes += f.size();
		add_file(f, $urandom_range(0, 11) == 0);
	endtask

	// Driver: bursts of random length with random gaps; hold the payload while
	// in_ready is low and run the predictor on every accepted transaction.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		stream_tx_t tx;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			last      <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_frame_size(data_byte, last);
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_stream.size() != 0 &&
					!(byte_stream[0].hold_for_drain && pending_sizes.size() != 0)) begin
				tx = byte_stream.pop_front();
				in_valid  <= 1'b1;
				data_byte <= tx.it.data_byte;
				last      <= tx.it.last;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// Half of the bursts run back to back.
					burst_left = $urandom_range(1, 40);
					gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall out_ready on a changing pattern and check every result
	// against the oldest predicted frame size.
	ready_mode_e ready_mode = RDY_ALWAYS;
	int          mode_left  = 0;
	int          stall_left = 0;
	logic [1:0]  beat = 2'd0;

	always @(posedge clk or negedge arst_n) begin
		res_t exp_size;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_sizes.size() == 0) begin
					$error("unexpected result: found %0d height %0d width %0d",
						found, height, width);
					err_count++;
				end else begin
					exp_size = pending_sizes.pop_front();
					if (found !== exp_size.found) begin
						$error("found: expected %0d, actual %0d", exp_size.found, found);
						err_count++;
					end
					if (height !== exp_size.height) begin
						$error("height: expected %0d, actual %0d", exp_size.height, height);
						err_count++;
					end
					if (width !== exp_size.width) begin
						$error("width: expected %0d, actual %0d", exp_size.width, width);
						err_count++;
					end
				end
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			beat = beat + 2'd1;
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
				RDY_QUARTER: out_ready <= (beat == 2'd0);
				default: begin
					if (stall_left == 0) begin
						stall_left = $urandom_range(1, 12);
						out_ready <= 1'b1;
					end else begin
						stall_left--;
						out_ready <= 1'b0;
					end
				end
			endcase
		end
	end

	initial begin
		byte_list_t f;
		clear_scan_state();

		// SOF0 ending exactly on byte +9: only the found result, extreme size.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF0, 8'h00, 8'h11, 8'h08,
			8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
		add_file(f, 1'b0);
		// SOF2 with trailing bytes that must be dropped after the result.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF2, 8'h00, 8'h11, 8'h08,
			8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'h01, 8'h02};
		add_file(f, 1'b0);
		// Bad first byte, then bad second byte.
		f = '{8'h00, MARK_SOI};
		add_file(f, 1'b0);
		f = '{MARK_PREFIX, MARK_EOI, MARK_PREFIX, MARK_SOF0};
		add_file(f, 1'b0);
		// One-byte file.
		f = '{MARK_PREFIX};
		add_file(f, 1'b0);
		// File ends on byte +8 of the frame header.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF0, 8'h00, 8'h11, 8'h08,
			8'h12, 8'h34, 8'h56, 8'h78};
		add_file(f, 1'b0);
		// APP0 segment whose payload holds 0xFF bytes, then junk, then SOF0.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h00, 8'h04,
			MARK_PREFIX, MARK_PREFIX, 8'h11, MARK_PREFIX, MARK_SOF0, 8'h00, 8'h11,
			8'h08, 8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h00};
		add_file(f, 1'b0);
		// Length 0, marker byte 0xFF with length 1, a near-miss SOF1, then SOF2;
		// let the pipeline drain first.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_DQT, 8'h00, 8'h00,
			MARK_PREFIX, MARK_PREFIX, 8'h00, 8'h01, MARK_PREFIX, MARK_SOF1, 8'h00,
			8'h02, MARK_PREFIX, MARK_SOF2, 8'h00, 8'h11, 8'h08, 8'h01, 8'h23,
			8'h45, 8'h67, 8'h89};
		add_file(f, 1'b1);
		// File ends right on a marker prefix.
		f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};
		add_file(f, 1'b0);

		while (random_bytes < RANDOM_BYTES)
			add_random_file();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for the last transaction to be accepted, then for every result.
		while (byte_stream.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_sizes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("jpeg_frame_header_scanner_core_test: done, clean");
		else
			$display("jpeg_frame_header_scanner_core_test: done, errors");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("jpeg_frame_header_scanner_core_test: done, errors");
		$finish;
	end

endmodule

@@ jpeg_frame_header_scanner_core.f @@
+incdir+hdl
hdl/jfhs_pkg.sv
hdl/jfhs_in_reg.sv
hdl/jfhs_parser.sv
hdl/jfhs_out_reg.sv
hdl/jpeg_frame_header_scanner_core.sv
hdl/jfhs_checker.sv
tb/sv/jpeg_frame_header_scanner_core_test.sv
